>>> hw/rtl/adaptive_jitter_buffer_defines.svh
// Assertion helpers for the jitter buffer.
`ifndef ADAPTIVE_JITTER_BUFFER_DEFINES_SVH
`define ADAPTIVE_JITTER_BUFFER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define AJB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Condition that holds at every clock edge outside reset.
`define AJB_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`endif

>>> hw/rtl/ajb_pkg.sv
package ajb_pkg;

   localparam int Slots = 32;
   localparam int SlotBits = $clog2(Slots);
   localparam int MinDepth = 2;
   localparam int MaxDepth = 16;
   localparam int DepthBits = $clog2(MaxDepth + 1);
   localparam int OccBits = $clog2(Slots + 1);
   localparam int SlotWidth = 64;

   // Microseconds to milliseconds, a division by 1000: shift right by 3, then multiply by
   // ceil(2^36 / 125) and keep bits 58:36. Exact for every 32-bit value.
   localparam logic [29:0] Ms1000Recip = 30'd549755814;
   // Wait timeout: at least 100 full milliseconds since start.
   localparam logic [31:0] WaitTimeoutUs = 32'd100000;
   // Loss: more than 100 full milliseconds since the last arrival.
   localparam logic [31:0] LossTimeoutUs = 32'd101000;

   typedef enum logic [1:0] {
      OP_ARRIVE = 2'd0,
      OP_TICK   = 2'd1,
      OP_START  = 2'd2,
      OP_STOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_STORED  = 3'd0,
      KIND_PLAYED  = 3'd1,
      KIND_LOST    = 3'd2,
      KIND_NOTHING = 3'd3,
      KIND_CONTROL = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV1,
      ST_DIVN,
      ST_MEAN_MUL,
      ST_MEAN_DIV,
      ST_SCAN,
      ST_SCAN_END,
      ST_PLAY_RD,
      ST_PLAY,
      ST_CLEAR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] now_us;
      logic [31:0] sequence_req;
      logic [31:0] sender_time_us;
      logic [15:0] payload_handle;
      logic [15:0] samples_in;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [31:0] sequence_out;
      logic [15:0] handle_out;
      logic [15:0] samples_out;
      logic [4:0]  live_depth;
      logic [22:0] latency_now_ms;
      logic [22:0] latency_peak_ms;
      logic [22:0] latency_mean_ms;
      logic [31:0] received_count;
      logic [31:0] played_count;
      logic [31:0] lost_count;
      logic [31:0] growth_count;
   } rsp_type;

endpackage

>>> hw/rtl/ajb_ram.sv
module ajb_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/adaptive_jitter_buffer.sv
// Transaction steps: arrival runs a reciprocal multiply for the latency, then a 55-step serial
// divide for the running mean (skipped when the received count wraps to zero); a tick before
// playback begins runs the oldest-slot search, which reads the slot RAM one entry a cycle; stop
// clears the valid bits one slot a cycle while running.
// Throughput: one transaction at a time; the next is accepted once the result register is free.
// Synchronous active-high reset clears control state and statistics; slot RAM is not reset.
module adaptive_jitter_buffer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ajb_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ajb_pkg::rsp_type    rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_data
);
   import ajb_pkg::*;
   `include "adaptive_jitter_buffer_defines.svh"

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [7:0] setting_ff, setting_in;
   logic [Slots-1:0] valid_ff, valid_in;
   logic [OccBits-1:0] occ_ff, occ_in;
   logic running_ff, running_in, playing_ff, playing_in;
   logic [31:0] next_seq_ff, next_seq_in, start_ff, start_in;
   logic [31:0] last_ff, last_in, wait_ff, wait_in;
   logic [1:0] loss_ff, loss_in;
   logic [DepthBits-1:0] target_ff, target_in;
   logic [31:0] rcv_ff, rcv_in, ply_ff, ply_in, lost_ff, lost_in, grow_ff, grow_in;
   logic [22:0] lat_now_ff, lat_now_in, lat_peak_ff, lat_peak_in;
   logic [22:0] lat_mean_ff, lat_mean_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   // Serial divider: remainder, quotient/dividend shifter and divisor.
   logic [32:0] rem_ff, rem_in;
   logic [54:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [SlotBits:0] scan_ff, scan_in;
   logic found_ff, found_in;
   logic [31:0] best_ff, best_in;
   // Slot RAM: {sequence, handle, samples}.
   logic ram_we;
   logic [SlotBits-1:0] ram_waddr, ram_raddr;
   logic [SlotWidth-1:0] ram_wdata, ram_rdata;
   logic [31:0] rd_seq;
   logic [SlotBits-1:0] scan_prev;
   logic [32:0] rem_sh;
   logic [SlotBits-1:0] nidx;
   logic [31:0] el_wait, el_last;
   logic [DepthBits-1:0] clamp;
   logic [58:0] lat_prod;
   logic [22:0] lat_ms;

   ajb_ram #(.Width(SlotWidth), .Depth(Slots)) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign rd_seq = ram_rdata[63:32];
   assign scan_prev = SlotBits'(scan_ff - 1'b1);
   assign nidx = next_seq_ff[SlotBits-1:0];
   assign el_wait = req_ff.now_us - wait_ff;
   assign el_last = req_ff.now_us - last_ff;
   assign rem_sh = {rem_ff[31:0], quo_ff[54]};

   // Latency in milliseconds from the microsecond latency held in the low quotient bits.
   assign lat_prod = 59'(quo_ff[31:3]) * 59'(Ms1000Recip);
   assign lat_ms = lat_prod[58:36];

   // Clamp of the requested depth into the allowed window.
   always_comb begin
      if (setting_ff < 8'(MinDepth)) begin
         clamp = DepthBits'(MinDepth);
      end else if (setting_ff > 8'(MaxDepth)) begin
         clamp = DepthBits'(MaxDepth);
      end else begin
         clamp = DepthBits'(setting_ff);
      end
   end

   // Register update.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         setting_ff <= 8'd4;
         valid_ff <= '0;
         occ_ff <= '0;
         running_ff <= 1'b0;
         playing_ff <= 1'b0;
         next_seq_ff <= '0;
         start_ff <= '0;
         last_ff <= '0;
         wait_ff <= '0;
         loss_ff <= '0;
         target_ff <= DepthBits'(4);
         rcv_ff <= '0;
         ply_ff <= '0;
         lost_ff <= '0;
         grow_ff <= '0;
         lat_now_ff <= '0;
         lat_peak_ff <= '0;
         lat_mean_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         setting_ff <= setting_in;
         valid_ff <= valid_in;
         occ_ff <= occ_in;
         running_ff <= running_in;
         playing_ff <= playing_in;
         next_seq_ff <= next_seq_in;
         start_ff <= start_in;
         last_ff <= last_in;
         wait_ff <= wait_in;
         loss_ff <= loss_in;
         target_ff <= target_in;
         rcv_ff <= rcv_in;
         ply_ff <= ply_in;
         lost_ff <= lost_in;
         grow_ff <= grow_in;
         lat_now_ff <= lat_now_in;
         lat_peak_ff <= lat_peak_in;
         lat_mean_ff <= lat_mean_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      scan_ff <= scan_in;
      found_ff <= found_in;
      best_ff <= best_in;
   end

   // Sequencer: next state, datapath and RAM control.
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      setting_in = setting_ff;
      valid_in = valid_ff;
      occ_in = occ_ff;
      running_in = running_ff;
      playing_in = playing_ff;
      next_seq_in = next_seq_ff;
      start_in = start_ff;
      last_in = last_ff;
      wait_in = wait_ff;
      loss_in = loss_ff;
      target_in = target_ff;
      rcv_in = rcv_ff;
      ply_in = ply_ff;
      lost_in = lost_ff;
      grow_in = grow_ff;
      lat_now_in = lat_now_ff;
      lat_peak_in = lat_peak_ff;
      lat_mean_in = lat_mean_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      scan_in = scan_ff;
      found_in = found_ff;
      best_in = best_ff;
      ram_we = 1'b0;
      ram_waddr = req_ff.sequence_req[SlotBits-1:0];
      ram_wdata = {req_ff.sequence_req, req_ff.payload_handle, req_ff.samples_in};
      ram_raddr = nidx;

      if (csr_valid) begin
         setting_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               req_in = req_data;
               // Result fields common to every transaction; the kind is set per case.
               rsp_in.sequence_out = '0;
               rsp_in.handle_out = '0;
               rsp_in.samples_out = '0;
               case (op_type'(req_data.operation))
                  OP_ARRIVE: begin
                     // Latency in microseconds, wrapping at 32 bits.
                     quo_in = {23'd0,
                               req_data.now_us - start_ff - req_data.sender_time_us};
                     state_in = ST_DIV1;
                  end
                  OP_TICK: begin
                     if (!running_ff) begin
                        rsp_in.result_kind = KIND_NOTHING;
                        state_in = ST_OUT;
                     end else if (playing_ff) begin
                        state_in = ST_PLAY_RD;
                     end else begin
                        scan_in = '0;
                        found_in = 1'b0;
                        best_in = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_START: begin
                     if (!running_ff) begin
                        target_in = clamp;
                        running_in = 1'b1;
                        playing_in = 1'b0;
                        next_seq_in = '0;
                        start_in = req_data.now_us;
                        last_in = req_data.now_us;
                        wait_in = req_data.now_us;
                        loss_in = '0;
                     end
                     rsp_in.result_kind = KIND_CONTROL;
                     state_in = ST_OUT;
                  end
                  default: begin
                     if (running_ff) begin
                        running_in = 1'b0;
                        playing_in = 1'b0;
                        scan_in = '0;
                        state_in = ST_CLEAR;
                     end else begin
                        state_in = ST_OUT;
                     end
                     rsp_in.result_kind = KIND_CONTROL;
                  end
               endcase
            end
         end

         // Store the slot and update the latency statistics.
         ST_DIV1: begin
            ram_we = 1'b1;
            if (!valid_ff[req_ff.sequence_req[SlotBits-1:0]]) begin
               valid_in[req_ff.sequence_req[SlotBits-1:0]] = 1'b1;
               occ_in = occ_ff + 1'b1;
            end
            rcv_in = rcv_ff + 1'b1;
            lat_now_in = lat_ms;
            if (lat_ms > lat_peak_ff) begin
               lat_peak_in = lat_ms;
            end
            last_in = req_ff.now_us;
            rsp_in.result_kind = KIND_STORED;
            rsp_in.sequence_out = req_ff.sequence_req;
            if (rcv_in == '0) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_MEAN_MUL;
            end
         end

         // Restoring division by the received count, one quotient bit a cycle.
         ST_DIVN: begin
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = rem_sh - {1'b0, dvs_ff};
               quo_in = {quo_ff[53:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[53:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 6'd1) begin
               lat_mean_in = quo_in[22:0];
               state_in = ST_OUT;
            end
         end

         // Sum for the running mean: mean*(n-1)+now, then divide by n.
         ST_MEAN_MUL: begin
            quo_in = 55'(lat_mean_ff) * 55'(rcv_ff - 1'b1) + 55'(lat_now_ff);
            rem_in = '0;
            dvs_in = rcv_ff;
            cnt_in = 6'd55;
            state_in = ST_MEAN_DIV;
         end

         ST_MEAN_DIV: begin
            state_in = ST_DIVN;
         end

         // Oldest-slot search: one RAM read a cycle, each compared in the following cycle.
         ST_SCAN, ST_SCAN_END: begin
            ram_raddr = scan_ff[SlotBits-1:0];
            if (state_ff == ST_SCAN && !((occ_ff >= OccBits'(target_ff)) ||
                                         (el_wait >= WaitTimeoutUs && occ_ff != '0))) begin
               rsp_in.result_kind = KIND_NOTHING;
               state_in = ST_OUT;
            end else begin
               if (scan_ff != '0 && valid_ff[scan_prev] &&
                   (!found_ff || rd_seq < best_ff)) begin
                  best_in = rd_seq;
                  found_in = 1'b1;
               end
               scan_in = scan_ff + 1'b1;
               state_in = ST_SCAN_END;
               if (scan_ff == (SlotBits+1)'(Slots)) begin
                  if (found_in) begin
                     next_seq_in = best_in;
                     playing_in = 1'b1;
                     state_in = ST_PLAY_RD;
                  end else begin
                     rsp_in.result_kind = KIND_NOTHING;
                     state_in = ST_OUT;
                  end
               end
            end
         end

         ST_PLAY_RD: begin
            state_in = ST_PLAY;
         end

         // Play, declare lost or wait on the expected sequence.
         ST_PLAY: begin
            if (valid_ff[nidx] && rd_seq == next_seq_ff) begin
               valid_in[nidx] = 1'b0;
               occ_in = occ_ff - 1'b1;
               ply_in = ply_ff + 1'b1;
               next_seq_in = next_seq_ff + 1'b1;
               loss_in = '0;
               rsp_in.result_kind = KIND_PLAYED;
               rsp_in.sequence_out = next_seq_ff;
               rsp_in.handle_out = ram_rdata[31:16];
               rsp_in.samples_out = ram_rdata[15:0];
            end else if (el_last >= LossTimeoutUs) begin
               lost_in = lost_ff + 1'b1;
               next_seq_in = next_seq_ff + 1'b1;
               loss_in = loss_ff + 1'b1;
               if (loss_ff == 2'd2) begin
                  loss_in = '0;
                  if (target_ff < DepthBits'(MaxDepth)) begin
                     target_in = target_ff + 1'b1;
                     grow_in = grow_ff + 1'b1;
                  end
               end
               rsp_in.result_kind = KIND_LOST;
               rsp_in.sequence_out = next_seq_ff;
            end else begin
               rsp_in.result_kind = KIND_NOTHING;
               rsp_in.sequence_out = next_seq_ff;
            end
            state_in = ST_OUT;
         end

         // Stop sweep: one valid bit a cycle, occupancy follows each cleared slot.
         ST_CLEAR: begin
            if (valid_ff[scan_ff[SlotBits-1:0]]) begin
               valid_in[scan_ff[SlotBits-1:0]] = 1'b0;
               occ_in = occ_ff - 1'b1;
            end
            scan_in = scan_ff + 1'b1;
            rsp_in.result_kind = KIND_CONTROL;
            if (scan_ff == (SlotBits+1)'(Slots - 1)) begin
               state_in = ST_OUT;
            end
         end

         // Capture statistics into the result register.
         ST_OUT: begin
            rsp_in.sequence_out = rsp_ff.sequence_out;
            rsp_in.handle_out = rsp_ff.handle_out;
            rsp_in.samples_out = rsp_ff.samples_out;
            rsp_in.live_depth = 5'(target_ff);
            rsp_in.latency_now_ms = lat_now_ff;
            rsp_in.latency_peak_ms = lat_peak_ff;
            rsp_in.latency_mean_ms = lat_mean_ff;
            rsp_in.received_count = rcv_ff;
            rsp_in.played_count = ply_ff;
            rsp_in.lost_count = lost_ff;
            rsp_in.growth_count = grow_ff;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Occupancy always matches the number of valid slots.
   `AJB_ASSERT_ALWAYS(a_occ_count, clock, reset, occ_ff == OccBits'($countones(valid_ff)))
   // No new transaction is taken while a result waits.
   `AJB_ASSERT_IMPL(a_no_accept_pending, clock, reset, rsp_valid_ff, req_stall)
   // Playing implies running.
   `AJB_ASSERT_IMPL(a_play_run, clock, reset, playing_ff, running_ff)

endmodule
